// ===== rtl/dense_matrix_product_engine_defines.svh =====
// Assertion macros used by the matrix product engine back end.
`ifndef DENSE_MATRIX_PRODUCT_ENGINE_DEFINES_SVH
`define DENSE_MATRIX_PRODUCT_ENGINE_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define DMPE_CHECK(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dmpe check failed");

// Next-cycle implication, off while reset is high.
`define DMPE_CHECK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dmpe next-cycle check failed");

`endif

// ===== rtl/dmpe_pkg.sv =====
// Types, constants and codes of the dense matrix product engine.
package dmpe_pkg;

  localparam int MAX_N     = 16;
  localparam int MEM_DEPTH = MAX_N * MAX_N;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int N_W       = $clog2(MAX_N + 1);
  localparam int K_W       = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int ACC_W     = 64 + N_W;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
  localparam int CFG_W     = 5;

  // Input kinds.
  localparam logic [1:0] KIND_LOAD_A = 2'd0;
  localparam logic [1:0] KIND_LOAD_B = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  // Commands handed from front to back.
  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_ZERO   = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] product;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
    logic [N_W-1:0]     n;
  } cmd_t;

endpackage

// ===== rtl/dmpe_front.sv =====
// Front end: size register and classification of incoming items.
module dmpe_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [dmpe_pkg::CFG_W-1:0] cfg_data,
  input  logic              push,
  input  dmpe_pkg::in_item_t item,
  output logic              full,
  input  logic              q_full,
  output logic              q_push,
  output dmpe_pkg::cmd_t    q_cmd
);

  logic [dmpe_pkg::CFG_W-1:0] size;
  logic [dmpe_pkg::N_W-1:0]   eff_n;
  logic                       in_store;
  logic                       in_matrix;
  logic                       keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= dmpe_pkg::CFG_W'(dmpe_pkg::MAX_N);
    end else if (cfg_we) begin
      size <= cfg_data;
    end
  end

  // Clamp the size register into 1..MAX_N.
  always_comb begin
    if (size == '0) begin
      eff_n = dmpe_pkg::N_W'(1);
    end else if (int'(size) > dmpe_pkg::MAX_N) begin
      eff_n = dmpe_pkg::N_W'(dmpe_pkg::MAX_N);
    end else begin
      eff_n = dmpe_pkg::N_W'(size);
    end
  end

  assign in_store  = (int'(item.row) < dmpe_pkg::MAX_N) && (int'(item.col) < dmpe_pkg::MAX_N);
  assign in_matrix = (int'(item.row) < int'(eff_n)) && (int'(item.col) < int'(eff_n));

  // Drop unused kinds and loads outside the storage; queries outside the matrix become zero commands.
  always_comb begin
    q_cmd.row   = item.row;
    q_cmd.col   = item.col;
    q_cmd.value = item.value;
    q_cmd.n     = eff_n;
    q_cmd.op    = dmpe_pkg::OP_ZERO;
    keep        = 1'b0;
    unique case (item.kind)
      dmpe_pkg::KIND_LOAD_A: begin
        q_cmd.op = dmpe_pkg::OP_LOAD_A;
        keep     = in_store;
      end
      dmpe_pkg::KIND_LOAD_B: begin
        q_cmd.op = dmpe_pkg::OP_LOAD_B;
        keep     = in_store;
      end
      dmpe_pkg::KIND_QUERY: begin
        q_cmd.op = in_matrix ? dmpe_pkg::OP_QUERY : dmpe_pkg::OP_ZERO;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full   = q_full;
  assign q_push = push && !q_full && keep;

endmodule

// ===== rtl/dmpe_cmd_queue.sv =====
// Short command queue between front and back.
module dmpe_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_en,
  input  dmpe_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop_en,
  output logic           empty,
  output dmpe_pkg::cmd_t head
);

  dmpe_pkg::cmd_t                slots [dmpe_pkg::Q_DEPTH];
  logic [dmpe_pkg::Q_PTR_W-1:0]  wr_ptr;
  logic [dmpe_pkg::Q_PTR_W-1:0]  rd_ptr;
  logic [dmpe_pkg::Q_CNT_W-1:0]  count;
  logic                          do_push;
  logic                          do_pop;

  assign full    = (int'(count) == dmpe_pkg::Q_DEPTH);
  assign empty   = (count == '0);
  assign do_push = push_en && !full;
  assign do_pop  = pop_en && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (int'(wr_ptr) == dmpe_pkg::Q_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (int'(rd_ptr) == dmpe_pkg::Q_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/dmpe_back.sv =====
// Back end: matrix storage, multiply-accumulate pipeline and result register.
`include "dense_matrix_product_engine_defines.svh"

module dmpe_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  dmpe_pkg::cmd_t        q_head,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output dmpe_pkg::out_item_t   result
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]                    state;
  logic [dmpe_pkg::K_W-1:0]      k;
  logic [3:0]                    cur_row;
  logic [3:0]                    cur_col;
  logic [dmpe_pkg::N_W-1:0]      cur_n;
  logic                          k_last;

  logic [31:0]                   mem_a [dmpe_pkg::MEM_DEPTH];
  logic [31:0]                   mem_b [dmpe_pkg::MEM_DEPTH];
  logic [dmpe_pkg::ADDR_W-1:0]   wr_addr;
  logic [dmpe_pkg::ADDR_W-1:0]   rd_addr_a;
  logic [dmpe_pkg::ADDR_W-1:0]   rd_addr_b;
  logic [31:0]                   a_rd;
  logic [31:0]                   b_rd;
  logic                          we_a;
  logic                          we_b;

  logic                          rd_vld;
  logic                          rd_last;
  logic                          mul_vld;
  logic                          mul_last;
  logic signed [63:0]            mul_p;
  logic signed [dmpe_pkg::ACC_W-1:0] acc;
  logic signed [dmpe_pkg::ACC_W-1:0] acc_sum;
  logic                          fits;
  logic                          res_valid;
  logic                          res_set;
  dmpe_pkg::out_item_t           res_next;
  logic                          start_query;
  logic                          zero_res;

  // Loads go once the back end is idle; queries also wait for a free result register.
  always_comb begin
    q_pop = 1'b0;
    if (state == ST_IDLE && !q_empty) begin
      q_pop = (q_head.op == dmpe_pkg::OP_LOAD_A) || (q_head.op == dmpe_pkg::OP_LOAD_B)
              || !res_valid;
    end
  end

  assign we_a        = q_pop && (q_head.op == dmpe_pkg::OP_LOAD_A);
  assign we_b        = q_pop && (q_head.op == dmpe_pkg::OP_LOAD_B);
  assign start_query = q_pop && (q_head.op == dmpe_pkg::OP_QUERY);
  assign zero_res    = q_pop && (q_head.op == dmpe_pkg::OP_ZERO);
  assign k_last      = (dmpe_pkg::N_W'(k) + dmpe_pkg::N_W'(1)) == cur_n;

  assign wr_addr   = dmpe_pkg::ADDR_W'(int'(q_head.row) * dmpe_pkg::MAX_N + int'(q_head.col));
  assign rd_addr_a = dmpe_pkg::ADDR_W'(int'(cur_row) * dmpe_pkg::MAX_N + int'(k));
  assign rd_addr_b = dmpe_pkg::ADDR_W'(int'(k) * dmpe_pkg::MAX_N + int'(cur_col));

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wr_addr] <= q_head.value;
    end
    a_rd <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[wr_addr] <= q_head.value;
    end
    b_rd <= mem_b[rd_addr_b];
  end

  assign acc_sum = acc + dmpe_pkg::ACC_W'(mul_p);
  assign fits    = (&acc_sum[dmpe_pkg::ACC_W-1:63]) || !(|acc_sum[dmpe_pkg::ACC_W-1:63]);

  // Saturate the final sum into 64 bits; a zero command sets a zero result.
  always_comb begin
    res_set = 1'b0;
    res_next.product  = '0;
    res_next.overflow = 1'b0;
    if (mul_vld && mul_last) begin
      res_set = 1'b1;
      if (fits) begin
        res_next.product = acc_sum[63:0];
      end else begin
        res_next.product  = acc_sum[dmpe_pkg::ACC_W-1] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        res_next.overflow = 1'b1;
      end
    end else if (zero_res) begin
      res_set = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_vld    <= 1'b0;
      rd_last   <= 1'b0;
      mul_vld   <= 1'b0;
      mul_last  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      rd_vld   <= (state == ST_ISSUE);
      rd_last  <= (state == ST_ISSUE) && k_last;
      mul_vld  <= rd_vld;
      mul_last <= rd_last;
      if (res_set) begin
        res_valid <= 1'b1;
      end else if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (start_query) begin
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (k_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (mul_vld && mul_last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    if (start_query) begin
      k       <= '0;
      cur_row <= q_head.row;
      cur_col <= q_head.col;
      cur_n   <= q_head.n;
      acc     <= '0;
    end else begin
      if (state == ST_ISSUE) begin
        k <= k + 1'b1;
      end
      if (mul_vld) begin
        acc <= acc_sum;
      end
    end
    mul_p <= $signed(a_rd) * $signed(b_rd);
    if (res_set) begin
      result <= res_next;
    end
  end

  assign empty = !res_valid;

  `DMPE_CHECK(a_busy_no_result, clk, rst, state != ST_IDLE, !res_valid)
  `DMPE_CHECK_NEXT(a_last_gives_result, clk, rst, mul_vld && mul_last, res_valid)
  `DMPE_CHECK(a_issue_in_range, clk, rst, state == ST_ISSUE, dmpe_pkg::N_W'(k) < cur_n)
  `DMPE_CHECK(a_mac_only_busy, clk, rst, mul_vld, state == ST_ISSUE || state == ST_DRAIN)

endmodule

// ===== rtl/dense_matrix_product_engine.sv =====
// Top level of the dense matrix product engine (C = A x B, Q16.16 in, Q32.32 out).
//
// Usage:
//   Input channel (push/full/item): an item is taken on a clock edge with push
//   high and full low. Kind 0 loads A[row][col], kind 1 loads B[row][col],
//   kind 2 queries C[row][col]; kind 3 is dropped. Only queries give results.
//   Result channel (empty/pop/result): the oldest result sits on result while
//   empty is low and leaves on an edge with pop high.
//   Configuration: cfg_we/cfg_data write size_in_use (n); 0 acts as 1, values
//   above 16 act as 16. Write it only while the engine is idle.
// Timing:
//   Items pass a two-entry command queue. A load is written to its memory as
//   it is dequeued. A query inside the matrix is dequeued, then the A and B
//   memories are read one element pair per cycle (one read port each), then
//   the products pass the multiply and accumulate stages. A query outside
//   the matrix answers zero in the cycle after its dequeue.
// Stall: a waiting result holds the next query at the head of the queue, and
//   the commands behind it wait too; full rises once the queue holds two commands.
// Reset: clears queue, pipeline and result; size returns to 16. Matrix
//   contents are undefined until loaded.
module dense_matrix_product_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [dmpe_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         push,
  output logic                         full,
  input  dmpe_pkg::in_item_t           item,
  output logic                         empty,
  input  logic                         pop,
  output dmpe_pkg::out_item_t          result
);

  // Front-to-queue and queue-to-back command links.
  logic           q_push;
  logic           q_full;
  dmpe_pkg::cmd_t q_in;
  logic           q_pop;
  logic           q_empty;
  dmpe_pkg::cmd_t q_head;

  // Classify items and hold the size register.
  dmpe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .push     (push),
    .item     (item),
    .full     (full),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_in)
  );

  // Decouple front and back so each stalls on its own.
  dmpe_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_en  (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop_en   (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Execute loads and dot products, hold the result until popped.
  dmpe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the dense matrix product engine: loads, queries, saturation.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dmpe_pkg::*;

  // Kind code that the engine must drop without a result.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Q16.16 extremes used by the directed items.
  localparam logic [31:0] ELEM_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] ELEM_MIN = 32'h8000_0000;

  // Cycles to let pass once nothing is awaited: covers a query through queue and back end.
  localparam int SETTLE_CYCLES = 40;
  // Long receiver hold-off that forces the command queue to fill and raise full.
  localparam int HOLD_AT_ITEM  = 700;
  localparam int HOLD_CYCLES   = 400;
  // Hard stop, far above the slowest legal run.
  localparam int CYCLE_LIMIT   = 1_000_000;
  // Items per random phase after the fill loads.
  localparam int MIXED_ITEMS   = 115;

  logic                 clk;
  logic                 rst      = 1'b1;
  logic                 cfg_we   = 1'b0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 push     = 1'b0;
  logic                 full;
  in_item_t             item     = '0;
  logic                 empty;
  logic                 pop      = 1'b0;
  out_item_t            result;

  dense_matrix_product_engine dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .item     (item),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Items waiting to be offered, filled by the stimulus process.
  in_item_t  pending_items[$];
  // C elements expected back, oldest first.
  out_item_t awaited_products[$];

  // Shadow copy of the matrices (updated on accepted items) and of the size register.
  logic signed [31:0] a_elems [MAX_N][MAX_N];
  logic signed [31:0] b_elems [MAX_N][MAX_N];
  logic [CFG_W-1:0]   size_setting = CFG_W'(MAX_N);

  // Generator-side record of which elements have been loaded; queries in range
  // are only issued once every element they read has been written.
  bit a_written [MAX_N][MAX_N];
  bit b_written [MAX_N][MAX_N];

  int error_count    = 0;
  int items_accepted = 0;
  int cycle_count    = 0;
  bit calm           = 1'b0;   // set for the last phase: no idling at all

  // Map the register to the dimension in use: 0 acts as 1, above MAX_N as MAX_N.
  function automatic int active_n(logic [CFG_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_N) return MAX_N;
    return int'(s);
  endfunction

  // Dot product of row r of A with column c of B, kept exact in 72 bits and
  // saturated to signed Q32.32 at the end.
  function automatic out_item_t product_at(logic [3:0] r, logic [3:0] c);
    out_item_t          res;
    logic signed [71:0] sum;
    logic signed [63:0] term;
    int                 n;
    n   = active_n(size_setting);
    res = '0;
    if (r >= n || c >= n) return res;
    sum = '0;
    for (int k = 0; k < n; k++) begin
      term = a_elems[r][k] * b_elems[k][c];
      sum  = sum + term;
    end
    if (sum[71:63] == '0 || sum[71:63] == '1) begin
      res.product = sum[63:0];
    end else begin
      res.overflow = 1'b1;
      res.product  = sum[71] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end
    return res;
  endfunction

  // Advance the shadow state by one accepted item; queries add an expectation.
  function automatic void absorb_item(in_item_t it);
    case (it.kind)
      KIND_LOAD_A: a_elems[it.row][it.col] = it.value;
      KIND_LOAD_B: b_elems[it.row][it.col] = it.value;
      KIND_QUERY:  awaited_products.push_back(product_at(it.row, it.col));
      default: ;
    endcase
  endfunction

  // Driver: offer the head of pending_items; hold it while full is high, and
  // idle in random bursts only between items.
  int send_left = 0;
  bit send_idle = 1'b0;

  always @(posedge clk) begin
    bit holding;
    if (rst) begin
      push <= 1'b0;
    end else begin
      holding = push && full;
      if (push && !full) begin
        absorb_item(item);
        void'(pending_items.pop_front());
        items_accepted <= items_accepted + 1;
      end
      if (!holding) begin
        if (send_left == 0) begin
          send_idle = !calm && ($urandom_range(0, 3) == 0);
          send_left = send_idle ? $urandom_range(1, 16) : $urandom_range(1, 32);
        end
        send_left = send_left - 1;
      end
      if (holding) begin
        push <= 1'b1;
      end else if (!send_idle && pending_items.size() > 0) begin
        push <= 1'b1;
        item <= pending_items[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: compare each popped result with the oldest expectation, then
  // decide whether to pop next cycle (random stalls, one long hold-off).
  int take_left = 0;
  bit take_idle = 1'b0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (awaited_products.size() == 0) begin
          $error("result with no query waiting: product %0d overflow %0b",
                 result.product, result.overflow);
          error_count = error_count + 1;
        end else begin
          want = awaited_products.pop_front();
          if (result.product !== want.product) begin
            $error("product: expected %0d, got %0d", want.product, result.product);
            error_count = error_count + 1;
          end
          if (result.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, result.overflow);
            error_count = error_count + 1;
          end
        end
      end
      if (!hold_done && items_accepted >= HOLD_AT_ITEM) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        pop <= 1'b0;
      end else begin
        if (take_left == 0) begin
          take_idle = !calm && ($urandom_range(0, 3) == 0);
          take_left = take_idle ? $urandom_range(1, 16) : $urandom_range(1, 32);
        end
        take_left = take_left - 1;
        pop <= !take_idle;
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Add one item to the stimulus and note which element it writes.
  task automatic enqueue(logic [1:0] kind, int r, int c, logic [31:0] v);
    in_item_t it;
    it.kind  = kind;
    it.row   = r[3:0];
    it.col   = c[3:0];
    it.value = v;
    if (kind == KIND_LOAD_A) a_written[r][c] = 1'b1;
    if (kind == KIND_LOAD_B) b_written[r][c] = 1'b1;
    pending_items.push_back(it);
  endtask

  // Element values: mostly full random, with the extremes and small values mixed in.
  function automatic logic [31:0] pick_elem();
    case ($urandom_range(0, 9))
      0:       return ELEM_MAX;
      1:       return ELEM_MIN;
      2:       return 32'($urandom_range(0, 32'h0003_FFFF));
      3:       return -32'($urandom_range(0, 32'h0003_FFFF));
      default: return $urandom();
    endcase
  endfunction

  // Wait until every item is taken and every result is back, then let the
  // engine run dry before touching the size register.
  task automatic settle();
    while (pending_items.size() != 0 || push || awaited_products.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write size_in_use while idle; the shadow copy follows at the same edge.
  task automatic set_size(int v);
    cfg_we       <= 1'b1;
    cfg_data     <= CFG_W'(v);
    size_setting  = CFG_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One random phase: load any element of the n x n block not yet written,
  // then a mix of loads, queries inside and outside the matrix, and noise.
  task automatic random_phase(int cfg);
    int n;
    int r;
    int c;
    int roll;
    set_size(cfg);
    n = active_n(CFG_W'(cfg));
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if (!a_written[i][j]) enqueue(KIND_LOAD_A, i, j, pick_elem());
        if (!b_written[i][j]) enqueue(KIND_LOAD_B, i, j, pick_elem());
      end
    end
    for (int i = 0; i < MIXED_ITEMS; i++) begin
      roll = $urandom_range(0, 99);
      r    = $urandom_range(0, n - 1);
      c    = $urandom_range(0, n - 1);
      if (roll < 35) begin
        enqueue($urandom_range(0, 1) ? KIND_LOAD_B : KIND_LOAD_A, r, c, pick_elem());
      end else if (roll < 45) begin
        // loads beyond n are legal and land in storage
        enqueue($urandom_range(0, 1) ? KIND_LOAD_B : KIND_LOAD_A,
                $urandom_range(0, MAX_N - 1), $urandom_range(0, MAX_N - 1), pick_elem());
      end else if (roll < 88 || n == MAX_N) begin
        if (roll >= 95) begin
          enqueue(KIND_UNUSED, $urandom_range(0, MAX_N - 1),
                  $urandom_range(0, MAX_N - 1), $urandom());
        end else begin
          enqueue(KIND_QUERY, r, c, $urandom());
        end
      end else if (roll < 95) begin
        // query outside the matrix: push one or both coordinates to n or beyond
        if ($urandom_range(0, 1)) r = $urandom_range(n, MAX_N - 1);
        else c = $urandom_range(n, MAX_N - 1);
        if ($urandom_range(0, 3) == 0) begin
          r = $urandom_range(n, MAX_N - 1);
          c = $urandom_range(n, MAX_N - 1);
        end
        enqueue(KIND_QUERY, r, c, $urandom());
      end else begin
        enqueue(KIND_UNUSED, $urandom_range(0, MAX_N - 1),
                $urandom_range(0, MAX_N - 1), $urandom());
      end
    end
    settle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset size: dropped kind and loads at the far corner with extreme values.
    enqueue(KIND_UNUSED, 15, 15, 32'hFFFF_FFFF);
    enqueue(KIND_LOAD_A, 15, 15, ELEM_MAX);
    enqueue(KIND_LOAD_B, 15, 15, ELEM_MIN);
    settle();

    // Smallest matrix: single products at the extremes, queries outside it.
    set_size(1);
    enqueue(KIND_LOAD_A, 0, 0, ELEM_MAX);
    enqueue(KIND_LOAD_B, 0, 0, ELEM_MAX);
    enqueue(KIND_QUERY, 0, 0, 32'h0);
    enqueue(KIND_QUERY, 0, 1, 32'h0);
    enqueue(KIND_QUERY, 15, 15, ELEM_MIN);
    enqueue(KIND_LOAD_A, 0, 0, ELEM_MIN);
    enqueue(KIND_LOAD_B, 0, 0, ELEM_MIN);
    enqueue(KIND_QUERY, 0, 0, 32'h0);
    enqueue(KIND_QUERY, 1, 0, 32'h0);
    settle();

    // Three terms: the largest positive products saturate high, mixed-sign
    // extreme products saturate low.
    set_size(3);
    enqueue(KIND_LOAD_A, 0, 1, ELEM_MIN);
    enqueue(KIND_LOAD_A, 0, 2, ELEM_MIN);
    enqueue(KIND_LOAD_B, 1, 0, ELEM_MIN);
    enqueue(KIND_LOAD_B, 2, 0, ELEM_MIN);
    enqueue(KIND_QUERY, 0, 0, 32'h0);
    enqueue(KIND_LOAD_B, 0, 0, ELEM_MAX);
    enqueue(KIND_LOAD_B, 1, 0, ELEM_MAX);
    enqueue(KIND_LOAD_B, 2, 0, ELEM_MAX);
    enqueue(KIND_QUERY, 0, 0, 32'h0);
    enqueue(KIND_QUERY, 0, 3, 32'h0);
    settle();

    // Random phases over sizes, including 0 and values above the maximum.
    random_phase(16);
    random_phase(0);
    random_phase(5);
    random_phase(31);
    random_phase(2);
    random_phase(12);
    random_phase(17);
    random_phase(8);
    random_phase(4);
    calm = 1'b1;
    random_phase(16);

    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dmpe_pkg.sv
rtl/dmpe_front.sv
rtl/dmpe_cmd_queue.sv
rtl/dmpe_back.sv
rtl/dense_matrix_product_engine.sv
verif/tb.sv
